// ===== src/mkne_pkg.sv =====
package mkne_pkg;

  localparam int NumberWidth = 32;
  localparam int QueueDepth = 2;
  localparam int QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0] EnterKeyReset = 8'd35;
  localparam logic [7:0] KeyZero = 8'h30;
  localparam logic [7:0] KeyNine = 8'h39;

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhRows = 4'b0010,
    PhCols = 4'b0100,
    PhWait = 4'b1000
  } scan_phase_t;

  typedef struct packed {
    logic       any_low;
    logic       col_found;
    logic [1:0] col_idx;
  } col_class_t;

  function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] code;
    case ({row, col})
      4'h0: code = "1";
      4'h1: code = "2";
      4'h2: code = "3";
      4'h3: code = "4";
      4'h4: code = "5";
      4'h5: code = "6";
      4'h6: code = "7";
      4'h7: code = "8";
      4'h8: code = "9";
      4'h9: code = "0";
      4'ha: code = "*";
      4'hb: code = "#";
      4'hc: code = "A";
      4'hd: code = "B";
      4'he: code = "C";
      default: code = "1";
    endcase
    return code;
  endfunction

  function automatic logic [3:0] single_row(input logic [1:0] row);
    return ~(4'b0001 << row);
  endfunction

endpackage

// ===== src/mkne_front.sv =====
module mkne_front import mkne_pkg::*; (
  input  logic [3:0]  column_pins,
  output col_class_t  cls
);

  always_comb begin
    cls.any_low = (column_pins != 4'hf);
    cls.col_found = 1'b0;
    cls.col_idx = 2'd0;
    for (int c = 3; c >= 0; c--) begin
      if (!column_pins[c]) begin
        cls.col_found = 1'b1;
        cls.col_idx = 2'(c);
      end
    end
  end

endmodule

// ===== src/mkne_queue.sv =====
module mkne_queue import mkne_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  col_class_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output col_class_t head_data
);

  col_class_t entries [QueueDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QCntW-1:0] count;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (count == QCntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mkne_back.sv =====
module mkne_back import mkne_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       enter_key_code,
  input  logic             head_valid,
  input  col_class_t       head_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       row_drive,
  output logic             key_valid,
  output logic [7:0]       key_code,
  output logic             key_is_digit,
  output logic [31:0]      number_value,
  output logic             number_ready
);

  scan_phase_t phase, phase_next;
  logic [1:0] scan_row, scan_row_next;
  logic [1:0] found_row, found_row_next;
  logic [7:0] held_key, held_key_next;
  logic [NumberWidth-1:0] acc, acc_next;

  logic [3:0] drive;
  logic valid_k, digit_k, ready_k;
  logic [7:0] code_k;
  logic [NumberWidth-1:0] value_k;
  logic [NumberWidth-1:0] acc_x10;
  logic [3:0] digit_val;

  assign pop = head_valid && (!out_valid || !out_stall);
  assign acc_x10 = (acc << 3) + (acc << 1);
  assign digit_val = 4'(held_key - KeyZero);

  always_comb begin
    phase_next = phase;
    scan_row_next = scan_row;
    found_row_next = found_row;
    held_key_next = held_key;
    acc_next = acc;
    drive = 4'h0;
    valid_k = 1'b0;
    digit_k = 1'b0;
    ready_k = 1'b0;
    code_k = 8'h00;
    case (phase)
      PhIdle: begin
        if (head_data.any_low) begin
          phase_next = PhRows;
          scan_row_next = 2'd0;
          drive = single_row(2'd0);
        end
      end
      PhRows: begin
        if (head_data.any_low) begin
          found_row_next = scan_row;
          phase_next = PhCols;
        end else if (scan_row == 2'd3) begin
          phase_next = PhIdle;
          scan_row_next = 2'd0;
        end else begin
          scan_row_next = scan_row + 2'd1;
          drive = single_row(scan_row + 2'd1);
        end
      end
      PhCols: begin
        if (head_data.col_found) begin
          held_key_next = key_lookup(found_row, head_data.col_idx);
          phase_next = PhWait;
        end else begin
          phase_next = PhIdle;
        end
      end
      PhWait: begin
        if (!head_data.any_low) begin
          phase_next = PhIdle;
          valid_k = 1'b1;
          code_k = held_key;
          if (held_key inside {[KeyZero:KeyNine]}) begin
            digit_k = 1'b1;
            acc_next = acc_x10 + {{(NumberWidth-4){1'b0}}, digit_val};
          end else if (held_key == enter_key_code) begin
            ready_k = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PhIdle;
      end
    endcase
    value_k = acc_next;
    if (ready_k) begin
      acc_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhIdle;
      scan_row <= 2'd0;
      found_row <= 2'd0;
      held_key <= 8'h00;
      acc <= '0;
      out_valid <= 1'b0;
    end else if (pop) begin
      phase <= phase_next;
      scan_row <= scan_row_next;
      found_row <= found_row_next;
      held_key <= held_key_next;
      acc <= acc_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_drive <= drive;
      key_valid <= valid_k;
      key_code <= code_k;
      key_is_digit <= digit_k;
      number_value <= 32'(value_k);
      number_ready <= ready_k;
    end
  end

endmodule

// ===== src/matrix_keypad_number_entry.sv =====
// 4x4 matrix keypad scanner with decimal number entry. Each item is one sample of the four
// active-low column pins; each result gives the active-low row pattern to drive next, the
// released key if any, and the running or finished number. The block takes one item per
// cycle while in_stall is low and returns one result per item, in order. An item passes
// a two-entry queue after column classification and then the scan state machine, whose
// single step per item (one times-ten add on the accumulator) sets the rate; results leave
// through an output register, which holds while out_stall is high. The enter key code is
// written through the configuration channel, resets to '#', and is always ready.
module matrix_keypad_number_entry import mkne_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  column_pins,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  row_drive,
  output logic        key_valid,
  output logic [7:0]  key_code,
  output logic        key_is_digit,
  output logic [31:0] number_value,
  output logic        number_ready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0] enter_key_code;
  col_class_t cls;
  col_class_t head_data;
  logic full, head_valid, pop;

  assign cfg_ready = 1'b1;
  assign in_stall = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_key_code <= EnterKeyReset;
    end else if (cfg_valid && cfg_ready) begin
      enter_key_code <= cfg_data;
    end
  end

  mkne_front u_front (
    .column_pins (column_pins),
    .cls         (cls)
  );

  mkne_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !full),
    .push_data  (cls),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  mkne_back u_back (
    .clk            (clk),
    .rst            (rst),
    .enter_key_code (enter_key_code),
    .head_valid     (head_valid),
    .head_data      (head_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .row_drive      (row_drive),
    .key_valid      (key_valid),
    .key_code       (key_code),
    .key_is_digit   (key_is_digit),
    .number_value   (number_value),
    .number_ready   (number_ready)
  );

endmodule

// ===== src/mkne_checker.sv =====
module mkne_checker import mkne_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  row_drive,
  input logic        key_valid,
  input logic [7:0]  key_code,
  input logic        key_is_digit,
  input logic [31:0] number_value,
  input logic        number_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(number_value) && $stable(key_code))
    else $error("result changed while stalled");

  a_ready_is_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && number_ready |-> key_valid && !key_is_digit)
    else $error("number ready without a non-digit key");

  a_digit_is_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_is_digit |-> key_valid && key_code >= KeyZero && key_code <= KeyNine)
    else $error("digit flag without a digit key");

  a_release_rows: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_valid |-> row_drive == 4'h0)
    else $error("rows not all low on key release");

endmodule

bind matrix_keypad_number_entry mkne_checker u_mkne_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .row_drive    (row_drive),
  .key_valid    (key_valid),
  .key_code     (key_code),
  .key_is_digit (key_is_digit),
  .number_value (number_value),
  .number_ready (number_ready)
);

// ===== test/testbench.sv =====
module testbench;
  import mkne_pkg::*;

  typedef struct {
    logic [3:0]  rows;
    logic        valid;
    logic [7:0]  code;
    logic        digit;
    logic [31:0] value;
    logic        ready;
  } key_report_t;

  class keypad_tracker;
    logic [7:0]             enter_code;
    scan_phase_t            phase;
    logic [2:0]             row_idx;
    logic [1:0]             hit_row;
    logic [7:0]             held_code;
    logic [NumberWidth-1:0] total;
    logic [3:0]             rows_now;
    key_report_t            due_reports[$];
    int                     errors;
    string                  layout;

    function new();
      layout = "1234567890*#ABC1";
      enter_code = EnterKeyReset;
      phase = PhIdle;
      row_idx = '0;
      hit_row = '0;
      held_code = '0;
      total = '0;
      rows_now = 4'h0;
      errors = 0;
    endfunction

    function void note_sample(input logic [3:0] cols);
      key_report_t r;
      logic any_low;
      int c;
      any_low = (cols != 4'hF);
      r = '{4'h0, 1'b0, 8'h00, 1'b0, 32'h0, 1'b0};
      case (phase)
        PhIdle: begin
          if (any_low) begin
            phase = PhRows;
            row_idx = '0;
            r.rows = 4'b1110;
          end
        end
        PhRows: begin
          if (any_low) begin
            hit_row = row_idx[1:0];
            phase = PhCols;
          end else begin
            row_idx = row_idx + 3'd1;
            if (row_idx >= 3'd4) begin
              phase = PhIdle;
              row_idx = '0;
            end else begin
              r.rows = ~(4'b0001 << row_idx[1:0]);
            end
          end
        end
        PhCols: begin
          c = 0;
          while (c < 4 && cols[c]) c++;
          if (c >= 4) begin
            phase = PhIdle;
          end else begin
            held_code = layout[hit_row * 4 + c];
            phase = PhWait;
          end
        end
        default: begin
          if (!any_low) begin
            phase = PhIdle;
            r.valid = 1'b1;
            r.code = held_code;
            if (held_code >= KeyZero && held_code <= KeyNine) begin
              r.digit = 1'b1;
              total = total * 10 + {24'h0, held_code - KeyZero};
            end else if (held_code == enter_code) begin
              r.ready = 1'b1;
            end
          end
        end
      endcase
      r.value = total[31:0];
      if (r.ready) total = '0;
      rows_now = r.rows;
      due_reports.push_back(r);
    endfunction

    function void compare(input string field, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_report(input logic [3:0] rows, input logic valid, input logic [7:0] code,
                               input logic digit, input logic [31:0] value, input logic ready);
      key_report_t e;
      if (due_reports.size() == 0) begin
        $display("%0t: result expected none actual rows=%h valid=%b code=%h digit=%b value=%h ready=%b",
                 $time, rows, valid, code, digit, value, ready);
        errors++;
        return;
      end
      e = due_reports.pop_front();
      compare("row_drive", e.rows, rows);
      compare("key_valid", e.valid, valid);
      compare("key_code", e.code, code);
      compare("key_is_digit", e.digit, digit);
      compare("number_value", e.value, value);
      compare("number_ready", e.ready, ready);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  column_pins;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  row_drive;
  logic        key_valid;
  logic [7:0]  key_code;
  logic        key_is_digit;
  logic [31:0] number_value;
  logic        number_ready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  keypad_tracker tracker = new();
  int burst_left = 0;
  int items_sent = 0;
  bit hold_request = 0;

  matrix_keypad_number_entry dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .column_pins  (column_pins),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_drive    (row_drive),
    .key_valid    (key_valid),
    .key_code     (key_code),
    .key_is_digit (key_is_digit),
    .number_value (number_value),
    .number_ready (number_ready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_report(row_drive, key_valid, key_code, key_is_digit, number_value,
                           number_ready);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= 2000) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin : receiver
    int mode;
    int span;
    int hold_left;
    int tick;
    mode = 0;
    span = 0;
    hold_left = 0;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 120);
        end
        span--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(input logic [3:0] cols);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    column_pins <= cols;
    do @(posedge clk); while (in_stall);
    tracker.note_sample(cols);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.due_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_enter_code(input logic [7:0] code);
    pause_until_drained();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= code;
    do @(posedge clk); while (!cfg_ready);
    tracker.enter_code = code;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [3:0] pin_pattern(input logic [15:0] held);
    logic [3:0] cols;
    int r;
    int c;
    cols = 4'hF;
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++)
        if (held[r * 4 + c] && !tracker.rows_now[r]) cols[c] = 1'b0;
    return cols;
  endfunction

  task automatic press_keys(input logic [15:0] held, input int hold, input int rel);
    int t;
    for (t = 0; t < hold + rel; t++)
      send_sample((t < hold) ? pin_pattern(held) : 4'hF);
  endtask

  task automatic tap(input int idx);
    press_keys(16'h1 << idx, idx / 4 + $urandom_range(3, 8), $urandom_range(1, 3));
  endtask

  function automatic int find_key(input logic [7:0] code);
    int i;
    for (i = 0; i < 16; i++)
      if (tracker.layout[i] == code) return i;
    return -1;
  endfunction

  initial begin : main
    logic [7:0] phase_codes[8];
    int p;
    int roll;
    int n;
    int k;
    int enter_idx;
    int idx;
    bit drain_pending;
    in_valid = 1'b0;
    column_pins = 4'hF;
    cfg_valid = 1'b0;
    cfg_data = 8'h00;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_sample(4'hF);
    press_keys(16'h0001, 3, 1);
    press_keys(16'h4000, 6, 1);
    press_keys(16'h0800, 5, 1);
    press_keys(16'h0020, 1, 4);
    press_keys(16'h0001, 2, 1);

    phase_codes[0] = 8'h00;
    phase_codes[1] = 8'hFF;
    phase_codes[2] = "5";
    phase_codes[3] = "*";
    phase_codes[4] = "A";
    phase_codes[5] = EnterKeyReset;
    phase_codes[6] = 8'($urandom_range(0, 255));
    phase_codes[7] = "1";

    for (p = 0; p < 8; p++) begin
      write_enter_code(phase_codes[p]);
      enter_idx = find_key(phase_codes[p]);
      if (p == 2) hold_request = 1;
      drain_pending = (p == 5);
      while (items_sent < 26 + (p + 1) * 92) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          n = $urandom_range(1, 14);
          for (k = 0; k < n; k++) begin
            idx = $urandom_range(0, 10);
            tap((idx == 10) ? 15 : idx);
          end
          if (enter_idx >= 0 && $urandom_range(0, 4) != 0) tap(enter_idx);
        end else if (roll < 70) begin
          tap($urandom_range(0, 15));
        end else if (roll < 80) begin
          press_keys(16'($urandom()), $urandom_range(1, 10), $urandom_range(0, 3));
        end else if (roll < 90) begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) send_sample(4'($urandom_range(0, 15)));
        end else begin
          idx = $urandom_range(0, 15);
          press_keys(16'h1 << idx, $urandom_range(1, idx / 4 + 2), $urandom_range(1, 5));
        end
        if (drain_pending) begin
          drain_pending = 0;
          pause_until_drained();
        end
      end
    end

    pause_until_drained();
    repeat (10) @(negedge clk);
    if (tracker.errors == 0 && tracker.due_reports.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
